// File: sv/hstkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstkv_pkg
// Shared types, codes and size defaults of the hashed sorted key/value table.
// ----------------------------------------------------------------------------
package hstkv_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int NAME_BYTES_DEF  = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CHAR_W          = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [2:0] ST_INSERTED     = 3'd0;
	localparam logic [2:0] ST_UPDATED      = 3'd1;
	localparam logic [2:0] ST_FULL         = 3'd2;
	localparam logic [2:0] ST_DELETED      = 3'd3;
	localparam logic [2:0] ST_DEL_MISSING  = 3'd4;
	localparam logic [2:0] ST_FOUND        = 3'd5;
	localparam logic [2:0] ST_SRCH_MISSING = 3'd6;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [CHAR_W-1:0] name_char;
		logic              last_char;
		logic [31:0]       salary_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_salary;
		logic [31:0] key_hash;
	} rsp_t;

endpackage

// File: sv/hstkv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstkv_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface hstkv_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: sv/hstkv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstkv_queue
// Short FIFO of finished key commands between the front and the back.
// ----------------------------------------------------------------------------
module hstkv_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);
	import hstkv_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    fill_q;
	logic             do_push, do_pop;

	assign full      = (fill_q == NW'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end
endmodule

// File: sv/hstkv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstkv_front
// Takes key characters, folds them into the running hash, buffers the name
// and hands a finished command to the queue on the last character.
// ----------------------------------------------------------------------------
module hstkv_front #(
	parameter int NAME_BYTES = hstkv_pkg::NAME_BYTES_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	hstkv_if.sink                                       req,
	input  logic                                        q_full,
	output logic                                        q_push,
	output logic [1:0]                                  cmd_op,
	output logic [31:0]                                 cmd_hash,
	output logic [(NAME_BYTES-1)*hstkv_pkg::CHAR_W-1:0] cmd_name,
	output logic                                        cmd_long,
	output logic [31:0]                                 cmd_salary
);
	import hstkv_pkg::*;

	localparam int KB = NAME_BYTES - 1;
	localparam int LW = $clog2(NAME_BYTES);

	logic [CHAR_W-1:0] buf_q [KB];
	logic [LW-1:0]     len_q;
	logic              long_q;
	logic [31:0]       hash_q;

	logic        accept, has_char, append;
	logic [31:0] h1, h2, h_next;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign has_char  = (req.data.name_char != '0);
	assign append    = has_char && (len_q < LW'(KB));

	always_comb begin
		h1     = hash_q + 32'(req.data.name_char);
		h2     = h1 + (h1 << 10);
		h_next = has_char ? (h2 ^ (h2 >> 6)) : hash_q;
	end

	// zero-pad the name past its length; the last character joins on the fly
	always_comb begin
		for (int j = 0; j < KB; j++) begin
			if (LW'(j) < len_q)
				cmd_name[j*CHAR_W +: CHAR_W] = buf_q[j];
			else if (LW'(j) == len_q && append)
				cmd_name[j*CHAR_W +: CHAR_W] = req.data.name_char;
			else
				cmd_name[j*CHAR_W +: CHAR_W] = '0;
		end
	end

	assign cmd_op     = req.data.opcode;
	assign cmd_hash   = h_next;
	assign cmd_long   = long_q || (has_char && !append);
	assign cmd_salary = req.data.salary_value;
	assign q_push     = accept && req.data.last_char &&
		(req.data.opcode inside {OP_INSERT, OP_DELETE, OP_SEARCH});

	always_ff @(posedge clk) begin
		if (accept && append) begin
			for (int j = 0; j < KB; j++)
				if (LW'(j) == len_q)
					buf_q[j] <= req.data.name_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			len_q  <= '0;
			long_q <= 1'b0;
		end else if (accept) begin
			if (req.data.last_char) begin
				hash_q <= '0;
				len_q  <= '0;
				long_q <= 1'b0;
			end else begin
				hash_q <= h_next;
				if (append)
					len_q <= len_q + 1'b1;
				else if (has_char)
					long_q <= 1'b1;
			end
		end
	end
endmodule

// File: sv/hstkv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hstkv_back
// Finishes the hash, then scans and shifts the sorted table one entry per
// step to run insert, delete or search, and holds the result for the sink.
// ----------------------------------------------------------------------------
module hstkv_back #(
	parameter int TABLE_DEPTH = hstkv_pkg::TABLE_DEPTH_DEF,
	parameter int NAME_BYTES  = hstkv_pkg::NAME_BYTES_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_valid,
	output logic                                        q_pop,
	input  logic [1:0]                                  cmd_op,
	input  logic [31:0]                                 cmd_hash,
	input  logic [(NAME_BYTES-1)*hstkv_pkg::CHAR_W-1:0] cmd_name,
	input  logic                                        cmd_long,
	input  logic [31:0]                                 cmd_salary,
	hstkv_if.source                                     rsp
);
	import hstkv_pkg::*;

	localparam int NW = (NAME_BYTES - 1) * CHAR_W;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_F1   = 4'd1;
	localparam logic [3:0] S_F2   = 4'd2;
	localparam logic [3:0] S_F3   = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_UR   = 4'd6;
	localparam logic [3:0] S_UW   = 4'd7;
	localparam logic [3:0] S_NEW  = 4'd8;
	localparam logic [3:0] S_DR   = 4'd9;
	localparam logic [3:0] S_DW   = 4'd10;

	logic [31:0]   hash_mem [TABLE_DEPTH];
	logic [31:0]   sal_mem  [TABLE_DEPTH];
	logic [NW-1:0] name_mem [TABLE_DEPTH];

	logic [31:0]   rd_hash_q, rd_sal_q;
	logic [NW-1:0] rd_name_q;

	logic [3:0]    state_q;
	logic [1:0]    op_q;
	logic [31:0]   hash_q, sal_q;
	logic [NW-1:0] name_q;
	logic          long_q;
	logic [CW-1:0] p_q, i_q, count_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_hash, wr_sal;
	logic [NW-1:0] wr_name;
	logic          hit, match, below, full;
	logic [CW-1:0] i_inc;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign q_pop     = (state_q == S_IDLE) && !out_valid_q && q_valid;

	assign hit   = (rd_hash_q == hash_q);
	assign match = hit && !long_q && (rd_name_q == name_q);
	assign below = (rd_hash_q < hash_q);
	assign full  = (count_q == CW'(TABLE_DEPTH));
	assign i_inc = i_q + 1'b1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = p_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = p_q[AW-1:0];
		wr_hash = rd_hash_q;
		wr_sal  = rd_sal_q;
		wr_name = rd_name_q;
		case (state_q)
			S_RD: rd_en = (p_q < count_q);
			S_CMP: begin
				if (!below && op_q == OP_INSERT && match) begin
					wr_en  = 1'b1;
					wr_sal = sal_q;
				end
			end
			S_UR: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			S_UW: begin
				wr_en   = 1'b1;
				wr_addr = i_inc[AW-1:0];
			end
			S_NEW: begin
				wr_en   = 1'b1;
				wr_hash = hash_q;
				wr_sal  = sal_q;
				wr_name = name_q;
			end
			S_DR: begin
				rd_en   = (i_inc < count_q);
				rd_addr = i_inc[AW-1:0];
			end
			S_DW: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hash_mem[wr_addr] <= wr_hash;
			sal_mem[wr_addr]  <= wr_sal;
			name_mem[wr_addr] <= wr_name;
		end
		if (rd_en) begin
			rd_hash_q <= hash_mem[rd_addr];
			rd_sal_q  <= sal_mem[rd_addr];
			rd_name_q <= name_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q   <= cmd_op;
			name_q <= cmd_name;
			long_q <= cmd_long;
			sal_q  <= cmd_salary;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hash_q      <= '0;
			p_q         <= '0;
			i_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						hash_q  <= cmd_hash;
						p_q     <= '0;
						state_q <= S_F1;
					end
				end
				S_F1: begin
					hash_q  <= hash_q + (hash_q << 3);
					state_q <= S_F2;
				end
				S_F2: begin
					hash_q  <= hash_q ^ (hash_q >> 11);
					state_q <= S_F3;
				end
				S_F3: begin
					hash_q  <= hash_q + (hash_q << 15);
					state_q <= S_RD;
				end
				S_RD: begin
					if (p_q < count_q) begin
						state_q <= S_CMP;
					end else if (op_q == OP_INSERT && !full) begin
						state_q <= S_NEW;
					end else begin
						out_valid_q        <= 1'b1;
						out_q.found_salary <= '0;
						out_q.key_hash     <= hash_q;
						out_q.status       <= (op_q == OP_INSERT) ? ST_FULL :
							(op_q == OP_DELETE) ? ST_DEL_MISSING : ST_SRCH_MISSING;
						state_q <= S_IDLE;
					end
				end
				S_CMP: begin
					out_q.key_hash     <= hash_q;
					out_q.found_salary <= '0;
					if (below) begin
						p_q     <= p_q + 1'b1;
						state_q <= S_RD;
					end else begin
						case (op_q)
							OP_INSERT: begin
								if (match) begin
									out_valid_q  <= 1'b1;
									out_q.status <= ST_UPDATED;
									state_q      <= S_IDLE;
								end else if (full) begin
									out_valid_q  <= 1'b1;
									out_q.status <= ST_FULL;
									state_q      <= S_IDLE;
								end else begin
									i_q     <= count_q - 1'b1;
									state_q <= S_UR;
								end
							end
							OP_DELETE: begin
								if (match) begin
									i_q     <= p_q;
									state_q <= S_DR;
								end else if (hit) begin
									// keep walking the run of equal hashes
									p_q     <= p_q + 1'b1;
									state_q <= S_RD;
								end else begin
									out_valid_q  <= 1'b1;
									out_q.status <= ST_DEL_MISSING;
									state_q      <= S_IDLE;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								if (match) begin
									out_q.status       <= ST_FOUND;
									out_q.found_salary <= rd_sal_q;
								end else begin
									out_q.status <= ST_SRCH_MISSING;
								end
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_UR: state_q <= S_UW;
				S_UW: begin
					if (i_q == p_q) begin
						state_q <= S_NEW;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_UR;
					end
				end
				S_NEW: begin
					count_q            <= count_q + 1'b1;
					out_valid_q        <= 1'b1;
					out_q.status       <= ST_INSERTED;
					out_q.found_salary <= '0;
					out_q.key_hash     <= hash_q;
					state_q            <= S_IDLE;
				end
				S_DR: begin
					if (i_inc < count_q) begin
						state_q <= S_DW;
					end else begin
						count_q            <= count_q - 1'b1;
						out_valid_q        <= 1'b1;
						out_q.status       <= ST_DELETED;
						out_q.found_salary <= '0;
						out_q.key_hash     <= hash_q;
						state_q            <= S_IDLE;
					end
				end
				S_DW: begin
					i_q     <= i_inc;
					state_q <= S_DR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: sv/hashed_sorted_key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_sorted_key_value_table_core
// Table of name/salary entries sorted by the one-at-a-time hash of the name.
//
//   channel  dir  carries
//   req      in   opcode, name_char, last_char, salary_value (one character)
//   rsp      out  status, found_salary, key_hash (one per final character of a valid opcode)
//
// A character is taken every cycle while the command queue has room.
// A command finishes its hash, then reads and compares table entries in order;
// an insert shifts the entries above its place up and writes the new entry,
// and a delete shifts the entries above its gap down to close it.
// Reset clears the entry count, the key state and the queue; memories are
// not cleared. A stalled result holds the back; the front keeps taking
// characters until the queue fills.
// ----------------------------------------------------------------------------
module hashed_sorted_key_value_table_core #(
	parameter int TABLE_DEPTH = hstkv_pkg::TABLE_DEPTH_DEF,
	parameter int NAME_BYTES  = hstkv_pkg::NAME_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	hstkv_if.sink   req,
	hstkv_if.source rsp
);
	import hstkv_pkg::*;

	localparam int NW = (NAME_BYTES - 1) * CHAR_W;
	localparam int QW = 2 + 32 + NW + 1 + 32;

	logic          f_push, q_full, q_valid, q_pop;
	logic [1:0]    f_op, b_op;
	logic [31:0]   f_hash, b_hash, f_sal, b_sal;
	logic [NW-1:0] f_name, b_name;
	logic          f_long, b_long;
	logic [QW-1:0] q_out;

	hstkv_front #(.NAME_BYTES(NAME_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.q_full     (q_full),
		.q_push     (f_push),
		.cmd_op     (f_op),
		.cmd_hash   (f_hash),
		.cmd_name   (f_name),
		.cmd_long   (f_long),
		.cmd_salary (f_sal)
	);

	hstkv_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_op, f_hash, f_name, f_long, f_sal}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	assign {b_op, b_hash, b_name, b_long, b_sal} = q_out;

	hstkv_back #(.TABLE_DEPTH(TABLE_DEPTH), .NAME_BYTES(NAME_BYTES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.cmd_op     (b_op),
		.cmd_hash   (b_hash),
		.cmd_name   (b_name),
		.cmd_long   (b_long),
		.cmd_salary (b_sal),
		.rsp        (rsp)
	);
endmodule

// File: tb/hashed_sorted_key_value_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_sorted_key_value_table_core_tb
// Streams key names character by character into the table core, predicts
// every insert, delete and search against a local sorted table, and checks
// each response field by field under random gaps and long response stalls.
// ----------------------------------------------------------------------------
module hashed_sorted_key_value_table_core_tb;
	import hstkv_pkg::*;

	localparam int DEPTH    = TABLE_DEPTH_DEF;
	localparam int NBYTES   = NAME_BYTES_DEF;
	localparam int IDLE_LIM = 20000;

	typedef logic [NBYTES*8-1:0] name_t;

	logic clk;
	logic arst_n;

	hstkv_if #(.T(req_t)) req ();
	hstkv_if #(.T(rsp_t)) rsp ();

	hashed_sorted_key_value_table_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// table predictor state
	logic [31:0] tbl_hash [DEPTH];
	logic [31:0] tbl_sal  [DEPTH];
	name_t       tbl_name [DEPTH];
	int          tbl_cnt;
	logic [31:0] run_hash;
	name_t       key_buf;
	int          key_len;
	bit          key_long;

	rsp_t rsp_expected [$];
	int   err_cnt;
	int   idle_cycles;
	bit   stall_long;
	bit   done;

	// pool of names so keys repeat and hit stored entries
	string name_pool [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit key_matches(int e);
		if (key_long)
			return 1'b0;
		return tbl_name[e] == key_buf;
	endfunction

	function automatic int first_not_below(logic [31:0] h);
		int p;
		p = 0;
		while (p < tbl_cnt && tbl_hash[p] < h)
			p++;
		return p;
	endfunction

	// fold one request into the predictor; push a response if one is due
	function automatic void predict_request(req_t r);
		logic [31:0] h;
		rsp_t        o;
		int          p;
		if (r.name_char != 0) begin
			run_hash = run_hash + 32'(r.name_char);
			run_hash = run_hash + (run_hash << 10);
			run_hash = run_hash ^ (run_hash >> 6);
			if (key_len < NBYTES - 1) begin
				key_buf[key_len*8 +: 8] = {1'b0, r.name_char};
				key_len++;
			end else begin
				key_long = 1'b1;
			end
		end
		if (!r.last_char)
			return;
		h = run_hash;
		h = h + (h << 3);
		h = h ^ (h >> 11);
		h = h + (h << 15);
		o = '0;
		o.key_hash = h;
		p = first_not_below(h);
		case (r.opcode)
			OP_INSERT: begin
				if (p < tbl_cnt && tbl_hash[p] == h && key_matches(p)) begin
					tbl_sal[p] = r.salary_value;
					o.status = ST_UPDATED;
				end else if (tbl_cnt >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (int i = tbl_cnt; i > p; i--) begin
						tbl_hash[i] = tbl_hash[i-1];
						tbl_sal[i]  = tbl_sal[i-1];
						tbl_name[i] = tbl_name[i-1];
					end
					tbl_hash[p] = h;
					tbl_sal[p]  = r.salary_value;
					tbl_name[p] = key_buf;
					tbl_cnt++;
					o.status = ST_INSERTED;
				end
			end
			OP_DELETE: begin
				while (p < tbl_cnt && tbl_hash[p] == h && !key_matches(p))
					p++;
				if (p < tbl_cnt && tbl_hash[p] == h) begin
					for (int i = p; i < tbl_cnt - 1; i++) begin
						tbl_hash[i] = tbl_hash[i+1];
						tbl_sal[i]  = tbl_sal[i+1];
						tbl_name[i] = tbl_name[i+1];
					end
					tbl_cnt--;
					o.status = ST_DELETED;
				end else begin
					o.status = ST_DEL_MISSING;
				end
			end
			OP_SEARCH: begin
				if (p < tbl_cnt && tbl_hash[p] == h && key_matches(p)) begin
					o.status       = ST_FOUND;
					o.found_salary = tbl_sal[p];
				end else begin
					o.status = ST_SRCH_MISSING;
				end
			end
			default: ;
		endcase
		if (r.opcode != 2'd3)
			rsp_expected.push_back(o);
		run_hash = '0;
		key_buf  = '0;
		key_len  = 0;
		key_long = 1'b0;
	endfunction

	task automatic send_char(req_t r);
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_request(r);
	endtask

	// stream a whole key; the salary and opcode ride on the final character
	task automatic send_key(string s, logic [1:0] op, logic [31:0] sal);
		req_t r;
		if (s.len() == 0) begin
			r = '{opcode: op, name_char: '0, last_char: 1'b1, salary_value: sal};
			send_char(r);
			return;
		end
		for (int i = 0; i < s.len(); i++) begin
			r.opcode       = (i == s.len() - 1) ? op : 2'($urandom);
			r.name_char    = 7'(s[i]);
			r.last_char    = (i == s.len() - 1);
			r.salary_value = (i == s.len() - 1) ? sal : $urandom;
			send_char(r);
		end
	endtask

	function automatic string rand_name(int len);
		string s;
		s = "";
		for (int i = 0; i < len; i++)
			s = {s, string'(8'($urandom_range(1, 127)))};
		return s;
	endfunction

	// response side: random ready with one long hold-off
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_long) begin
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				stall_long = 1'b0;
			end
			if ($urandom_range(0, 2) == 0 && !done) begin
				rsp.ready <= 1'b0;
				repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3))
					@(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// check every accepted response against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp_expected.size() == 0) begin
				$display("%0t unexpected response status=%0d", $realtime, rsp.data.status);
				err_cnt++;
			end else begin
				rsp_t e;
				e = rsp_expected.pop_front();
				if (rsp.data.status !== e.status) begin
					$display("%0t status exp %0d got %0d", $realtime, e.status,
						rsp.data.status);
					err_cnt++;
				end
				if (rsp.data.found_salary !== e.found_salary) begin
					$display("%0t found_salary exp %h got %h", $realtime,
						e.found_salary, rsp.data.found_salary);
					err_cnt++;
				end
				if (rsp.data.key_hash !== e.key_hash) begin
					$display("%0t key_hash exp %h got %h", $realtime, e.key_hash,
						rsp.data.key_hash);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	typedef struct {
		string       key;
		logic [1:0]  op;
		logic [31:0] sal;
		bit          typed;
		logic [2:0]  st;
	} step_t;

	step_t steps [$];

	initial begin
		string long_key;
		string s;
		int    n_keys;
		int    w;
		logic [1:0] op;
		err_cnt     = 0;
		stall_long  = 1'b0;
		done        = 1'b0;
		tbl_cnt     = 0;
		run_hash    = '0;
		key_buf     = '0;
		key_len     = 0;
		key_long    = 1'b0;
		req.valid   = 1'b0;
		req.data    = '0;
		arst_n      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		long_key = "abcdefghijklmnopqrst";
		// directed: empty name, extremes of characters, long key, every operation
		steps = '{
			'{"alice", OP_SEARCH, 32'h0,        1'b1, ST_SRCH_MISSING},
			'{"alice", OP_DELETE, 32'h0,        1'b1, ST_DEL_MISSING},
			'{"alice", OP_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED},
			'{"alice", OP_INSERT, 32'h0,        1'b1, ST_UPDATED},
			'{"alice", OP_SEARCH, 32'h0,        1'b0, ST_FOUND},
			'{"",      OP_INSERT, 32'h1234_5678, 1'b1, ST_INSERTED},
			'{"",      OP_SEARCH, 32'h0,        1'b0, ST_FOUND},
			'{"\x7f\x01\x7f", OP_INSERT, 32'hA5A5_A5A5, 1'b1, ST_INSERTED},
			'{"\x7f\x01\x7f", OP_SEARCH, 32'h0, 1'b0, ST_FOUND},
			'{long_key, OP_INSERT, 32'h5555_AAAA, 1'b1, ST_INSERTED},
			'{long_key, OP_INSERT, 32'h5555_AAAA, 1'b1, ST_INSERTED},
			'{long_key, OP_SEARCH, 32'h0,        1'b1, ST_SRCH_MISSING},
			'{long_key, OP_DELETE, 32'h0,        1'b1, ST_DEL_MISSING},
			'{"bob",   2'd3,      32'h0,        1'b0, ST_INSERTED},
			'{"bob",   OP_SEARCH, 32'h0,        1'b1, ST_SRCH_MISSING},
			'{"alice", OP_DELETE, 32'h0,        1'b1, ST_DELETED},
			'{"",      OP_DELETE, 32'h0,        1'b1, ST_DELETED},
			'{"abcdefghijklmno", OP_INSERT, 32'h7, 1'b1, ST_INSERTED},
			'{"abcdefghijklmno", OP_SEARCH, 32'h0, 1'b0, ST_FOUND}
		};
		foreach (steps[i]) begin
			send_key(steps[i].key, steps[i].op, steps[i].sal);
			if (steps[i].typed && rsp_expected.size() != 0 &&
				rsp_expected[$].status !== steps[i].st) begin
				$display("%0t directed row %0d status exp %0d predicted %0d", $realtime, i,
					steps[i].st, rsp_expected[$].status);
				err_cnt++;
			end
		end
		// a zero character in the middle of a name is dropped
		send_char('{OP_INSERT, 7'h41, 1'b0, 32'h0});
		send_char('{OP_INSERT, 7'h00, 1'b0, 32'h0});
		send_char('{OP_SEARCH, 7'h42, 1'b1, 32'h0});

		// fill past capacity to reach the full case, then drain
		for (int i = 0; i < DEPTH + 4; i++)
			send_key($sformatf("k%0d", i), OP_INSERT, $urandom);
		send_key("k3", OP_INSERT, 32'hDEAD_BEEF);
		send_key("k3", OP_SEARCH, 32'h0);

		// pause until every response has come
		req.valid <= 1'b0;
		while (rsp_expected.size() != 0)
			@(posedge clk);
		for (int i = 0; i < DEPTH + 4; i++)
			send_key($sformatf("k%0d", i), OP_DELETE, 32'h0);

		// long response hold-off while requests keep coming
		stall_long = 1'b1;
		for (int i = 0; i < 24; i++)
			name_pool.push_back(rand_name($urandom_range(1, 6)));
		n_keys = 0;
		w = 0;
		while (w < 300) begin
			if ($urandom_range(0, 9) == 0) begin
				s = rand_name($urandom_range(0, 20));
			end else begin
				s = name_pool[$urandom_range(0, name_pool.size() - 1)];
			end
			op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_key(s, op, $urandom);
			w += (s.len() == 0) ? 1 : s.len();
			n_keys++;
		end
		req.valid <= 1'b0;
		done = 1'b1;
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (4 * DEPTH + 50) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
